[rtl/bsp_pkg.sv]
package bsp_pkg;

  localparam int PACKET_BYTES = 20;
  localparam int POS_W        = $clog2(PACKET_BYTES);

  localparam logic [3:0] MODE_TEST    = 4'd0;
  localparam logic [3:0] MODE_FRAME   = 4'd1;
  localparam logic [3:0] MODE_ECG_RSP = 4'd2;
  localparam logic [3:0] MODE_RSP_LOW = 4'd3;
  localparam logic [3:0] MODE_ECG     = 4'd4;
  localparam logic [3:0] MODE_ECG_R2  = 4'd5;
  localparam logic [3:0] MODE_ALL     = 4'd6;
  localparam logic [3:0] MODE_TWO_CH  = 4'd7;
  localparam logic [3:0] MODE_PACK12  = 4'd8;

  typedef struct packed {
    logic [15:0] word0;
    logic [15:0] word1;
    logic [15:0] word2;
    logic [15:0] word3;
    logic [15:0] word4;
    logic [23:0] accel_bytes;
  } bsp_in_t;

  typedef struct packed {
    logic [7:0]       packet_byte;
    logic [POS_W-1:0] byte_position;
    logic             last_byte;
  } bsp_out_t;

  typedef struct packed {
    logic             item_load;
    logic             out_load;
    logic [POS_W-1:0] out_pos;
    logic             out_last;
    logic             seq_inc;
  } bsp_cmd_t;

  typedef struct packed {
    logic             complete;
    logic [POS_W-1:0] len;
    logic             bump;
  } bsp_sts_t;

  function automatic logic [2:0] twelve_bit_offset(input logic [2:0] slot);
    logic [2:0] off;
    case (slot)
      3'd0:    off = 3'd0;
      3'd1:    off = 3'd1;
      3'd2:    off = 3'd3;
      3'd3:    off = 3'd4;
      3'd4:    off = 3'd6;
      default: off = 3'd0;
    endcase
    return off;
  endfunction

endpackage

[rtl/bsp_datapath.sv]
module bsp_datapath import bsp_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic [3:0] cfg_wdata,
  input  bsp_in_t    in_data,
  input  bsp_cmd_t   cmd,
  output bsp_sts_t   sts,
  output bsp_out_t   out_data
);

  logic [3:0] mode_r;
  logic [3:0] slot_r, slot_nxt;
  logic [1:0] rsc_r, rsc_nxt;
  logic [7:0] buf_r   [PACKET_BYTES];
  logic [7:0] buf_nxt [PACKET_BYTES];
  logic [7:0] frame   [10];
  logic [15:0] w0, w3;
  logic [7:0] t8;
  logic [4:0] t1;
  logic [4:0] limit;
  logic       active;
  logic       resp_hit;
  logic [7:0] at1, at9;
  logic [7:0] jj;
  bsp_out_t   out_r;

  function automatic logic [7:0] put_byte(input logic [7:0] idx, input logic [7:0] j,
                                          input logic [7:0] cur, input logic [7:0] v);
    return (idx == j) ? v : cur;
  endfunction

  function automatic logic [7:0] put_word(input logic [7:0] idx, input logic [7:0] j,
                                          input logic [7:0] cur, input logic [7:0] lo,
                                          input logic [7:0] hi);
    logic [7:0] r;
    r = (idx == j) ? lo : cur;
    r = ((idx + 8'd1) == j) ? hi : r;
    return r;
  endfunction

  always_comb begin
    frame[0] = {4'h0, in_data.word0[3:0] + 4'd8};
    frame[1] = in_data.word0[15:8];
    frame[2] = {4'h0, in_data.word1[3:0] + 4'd8};
    frame[3] = in_data.word1[15:8];
    frame[4] = {4'h0, in_data.word2[3:0] + 4'd8};
    frame[5] = in_data.word2[15:8];
    frame[6] = {4'h0, in_data.word3[3:0] + 4'd8};
    frame[7] = in_data.word3[15:8];
    frame[8] = {4'h0, in_data.word4[3:0] + 4'd8};
    frame[9] = in_data.word4[15:8];
  end

  assign w0 = {frame[1], frame[0]};
  assign w3 = {frame[7], frame[6]};
  assign t8 = {4'h0, slot_r};
  assign t1 = {1'b0, slot_r} + 5'd1;
  assign resp_hit = (t1 == 5'd3) || (t1 == 5'd6);
  assign at1 = 8'd1 + {5'h0, twelve_bit_offset(slot_r[2:0])};
  assign at9 = 8'd9 + {5'h0, twelve_bit_offset(slot_r[2:0])};

  always_comb begin
    limit      = 5'd20;
    sts.len    = POS_W'(PACKET_BYTES);
    active     = 1'b1;
    sts.bump   = 1'b1;
    case (mode_r)
      MODE_TEST: begin
        limit    = 5'd2;
        sts.bump = 1'b0;
      end
      MODE_FRAME:   limit = 5'd2;
      MODE_ECG_RSP: limit = 5'd4;
      MODE_RSP_LOW: limit = 5'd6;
      MODE_ECG: begin
        limit   = 5'd9;
        sts.len = 5'd19;
      end
      MODE_ECG_R2: begin
        limit   = 5'd4;
        sts.len = 5'd17;
      end
      MODE_ALL:    limit = 5'd2;
      MODE_TWO_CH: limit = 5'd3;
      MODE_PACK12: begin
        limit   = 5'd5;
        sts.len = 5'd19;
      end
      default: active = 1'b0;
    endcase
    sts.complete = active && (t1 >= limit);
  end

  always_comb begin
    slot_nxt = slot_r;
    rsc_nxt  = rsc_r;
    if (active) begin
      if (mode_r == MODE_RSP_LOW && resp_hit) begin
        rsc_nxt = rsc_r + 2'd1;
      end
      if (sts.complete) begin
        slot_nxt = 4'h0;
        if (mode_r != MODE_TEST) begin
          rsc_nxt = 2'd0;
        end
      end else begin
        slot_nxt = t1[3:0];
      end
    end
  end

  always_comb begin
    for (int j = 0; j < PACKET_BYTES; j++) begin
      jj = 8'(j);
      buf_nxt[j] = buf_r[j];
      case (mode_r)
        MODE_TEST: begin
          if (sts.complete && j < PACKET_BYTES - 1) begin
            buf_nxt[j] = buf_r[j] + 8'd1;
          end
        end
        MODE_FRAME: begin
          for (int i = 0; i < 9; i++) begin
            buf_nxt[j] = put_byte(8'd1 + t8 * 8'd9 + 8'(i), jj, buf_nxt[j], frame[i]);
          end
        end
        MODE_ECG_RSP: begin
          buf_nxt[j] = put_word(8'd1 + 8'd2 * t8, jj, buf_nxt[j], frame[0], frame[1]);
          buf_nxt[j] = put_word(8'd9 + 8'd2 * t8, jj, buf_nxt[j], frame[2], frame[3]);
        end
        MODE_RSP_LOW: begin
          buf_nxt[j] = put_word(8'd1 + 8'd2 * t8, jj, buf_nxt[j], frame[0], frame[1]);
          if (resp_hit) begin
            buf_nxt[j] = put_word(8'd13 + {5'h0, rsc_r, 1'b0}, jj, buf_nxt[j],
                                  frame[4], frame[5]);
          end
        end
        MODE_ECG: begin
          buf_nxt[j] = put_word(8'd1 + 8'd2 * t8, jj, buf_nxt[j], frame[0], frame[1]);
        end
        MODE_ECG_R2: begin
          buf_nxt[j] = put_word(8'd1 + 8'd2 * t8, jj, buf_nxt[j], frame[0], frame[1]);
          buf_nxt[j] = put_word(8'd9 + 8'd2 * t8, jj, buf_nxt[j], frame[4], frame[5]);
        end
        MODE_ALL: begin
          buf_nxt[j] = put_word(8'd1 + 8'd2 * t8, jj, buf_nxt[j], frame[0], frame[1]);
          buf_nxt[j] = put_word(8'd5 + 8'd2 * t8, jj, buf_nxt[j], frame[6], frame[7]);
          buf_nxt[j] = put_word(8'd9 + 8'd2 * t8, jj, buf_nxt[j], frame[2], frame[3]);
          buf_nxt[j] = put_word(8'd13 + 8'd2 * t8, jj, buf_nxt[j], frame[4], frame[5]);
          if (t1 >= 5'd2) begin
            if (j == 17) buf_nxt[j] = in_data.accel_bytes[7:0];
            if (j == 18) buf_nxt[j] = in_data.accel_bytes[15:8];
            if (j == 19) buf_nxt[j] = in_data.accel_bytes[23:16];
          end
        end
        MODE_TWO_CH: begin
          buf_nxt[j] = put_word(8'd1 + 8'd2 * t8, jj, buf_nxt[j], frame[0], frame[1]);
          buf_nxt[j] = put_word(8'd7 + 8'd2 * t8, jj, buf_nxt[j], frame[6], frame[7]);
          if (t1 >= 5'd3) begin
            buf_nxt[j] = put_word(8'd13, jj, buf_nxt[j], frame[4], frame[5]);
          end
        end
        MODE_PACK12: begin
          if (slot_r == 4'd0 && j != 0) begin
            buf_nxt[j] = 8'h00;
          end
          if (slot_r < 4'd5) begin
            if (slot_r[0]) begin
              if (at1 == jj) buf_nxt[j] = buf_nxt[j] | {4'h0, w0[11:8]};
              buf_nxt[j] = put_byte(at1 + 8'd1, jj, buf_nxt[j], w0[7:0]);
              if (at9 == jj) buf_nxt[j] = buf_nxt[j] | {4'h0, w3[11:8]};
              buf_nxt[j] = put_byte(at9 + 8'd1, jj, buf_nxt[j], w3[7:0]);
            end else begin
              buf_nxt[j] = put_byte(at1, jj, buf_nxt[j], w0[11:4]);
              buf_nxt[j] = put_byte(at1 + 8'd1, jj, buf_nxt[j], {w0[3:0], 4'h0});
              buf_nxt[j] = put_byte(at9, jj, buf_nxt[j], w3[11:4]);
              buf_nxt[j] = put_byte(at9 + 8'd1, jj, buf_nxt[j], {w3[3:0], 4'h0});
            end
          end
          if (t1 >= 5'd5) begin
            buf_nxt[j] = put_word(8'd17, jj, buf_nxt[j], frame[4], frame[5]);
          end
        end
        default: buf_nxt[j] = buf_r[j];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_FRAME;
      slot_r <= 4'h0;
      rsc_r  <= 2'd0;
      for (int j = 0; j < PACKET_BYTES; j++) begin
        buf_r[j] <= 8'(j + 1);
      end
    end else begin
      if (cfg_we) begin
        mode_r <= cfg_wdata;
      end
      if (cmd.item_load) begin
        slot_r <= slot_nxt;
        rsc_r  <= rsc_nxt;
        for (int j = 0; j < PACKET_BYTES; j++) begin
          buf_r[j] <= buf_nxt[j];
        end
      end else if (cmd.seq_inc) begin
        buf_r[0] <= buf_r[0] + 8'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_r.packet_byte   <= buf_r[cmd.out_pos];
      out_r.byte_position <= cmd.out_pos;
      out_r.last_byte     <= cmd.out_last;
    end
  end

  assign out_data = out_r;

endmodule

[rtl/bsp_ctrl.sv]
module bsp_ctrl import bsp_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  input  bsp_sts_t sts,
  output bsp_cmd_t cmd
);

  typedef enum logic {ST_IDLE, ST_EMIT} state_t;

  state_t           state_r;
  logic [POS_W-1:0] idx_r;
  logic [POS_W-1:0] len_r;
  logic             bump_r;
  logic             out_valid_r;
  logic             fire;
  logic             last;

  assign in_ready = (state_r == ST_IDLE);
  assign fire     = (state_r == ST_EMIT) && (!out_valid_r || out_ready);
  assign last     = (idx_r == len_r - POS_W'(1));

  always_comb begin
    cmd.item_load = in_valid && in_ready;
    cmd.out_load  = fire;
    cmd.out_pos   = idx_r;
    cmd.out_last  = last;
    cmd.seq_inc   = fire && last && bump_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      idx_r       <= '0;
      len_r       <= '0;
      bump_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      case (state_r)
        ST_IDLE: begin
          if (cmd.item_load && sts.complete) begin
            state_r <= ST_EMIT;
            idx_r   <= '0;
            len_r   <= sts.len;
            bump_r  <= sts.bump;
          end
        end
        ST_EMIT: begin
          if (fire) begin
            idx_r <= idx_r + POS_W'(1);
            if (last) begin
              state_r <= ST_IDLE;
            end
          end
        end
        default: state_r <= ST_IDLE;
      endcase
      if (fire) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid = out_valid_r;

`ifndef SYNTHESIS
  a_enter_emit: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.item_load && sts.complete |=> state_r == ST_EMIT)
    else $error("completed packet did not start draining");

  a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_EMIT |-> idx_r < len_r)
    else $error("drain index beyond packet length");

  a_len_legal: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_EMIT |-> (len_r == 5'd17 || len_r == 5'd19 || len_r == 5'd20))
    else $error("illegal packet length");

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> !cmd.item_load)
    else $error("buffer update during drain");
`endif

endmodule

[rtl/biosignal_sample_packetizer.sv]
// Biosignal sample packetizer.
// cfg_we/cfg_wdata write the 4-bit packing mode (reset value 1); write only
// while the block is idle. in_valid/in_ready take one request per frame:
// five 16-bit frame words plus three accelerometer bytes. A request that does
// not finish a packet only updates the buffer and leaves the block idle. A
// request that finishes one starts a drain of 17, 19 or 20 bytes on
// out_valid/out_ready, one byte per cycle while out_ready is high, position in
// byte_position and last_byte on the final byte. On acceptance the controller
// enters its drain state and then loads the first byte into the output
// register. With out_ready held high, the byte index counter walks the packet
// buffer one entry per cycle. in_ready is low during the drain and returns as
// the last byte is loaded into the output register, so a new request can be
// taken while that byte still waits. If out_ready is low while out_valid is
// high, the output register holds its byte and the drain stops.
// Reset (rst_n low, synchronous) fills the buffer with 1..20, clears the slot
// counters and sets the mode to 1.
module biosignal_sample_packetizer import bsp_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic [3:0] cfg_wdata,
  input  logic       in_valid,
  output logic       in_ready,
  input  bsp_in_t    in_data,
  output logic       out_valid,
  input  logic       out_ready,
  output bsp_out_t   out_data
);

  bsp_cmd_t cmd;
  bsp_sts_t sts;

  bsp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  bsp_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_data  (out_data)
  );

endmodule
